// ===== hdl/acsf_pkg.sv =====
// Package for the adaptive channel smoothing filter.
// Holds shared widths, register indexes and the divider request/response types.
// No dependencies.
package acsf_pkg;

  // Channel and data widths
  localparam int CHANNELS  = 16;
  localparam int CH_W      = 4;
  localparam int DATA_W    = 16;
  localparam int WEIGHT_W  = 8;
  localparam int DEN_W     = WEIGHT_W + 1;
  localparam int NUM_W     = DATA_W + WEIGHT_W;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

  // Register reset values
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 8'd5;
  localparam logic [DATA_W-1:0]   THRESHOLD_RST = 16'd100;

  // Divider request: start pulse, numerator and divisor
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // Divider response: done pulse and quotient
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hdl/adaptive_channel_smoothing_filter.sv =====
// Top level of the adaptive channel smoothing filter.
// Depends on acsf_pkg and acsf_div.
//
// Per-channel smoothing filter: each transaction carries a channel index and a
// 16-bit sample, and returns the channel's updated smoothed value. A difference
// at or above the step threshold moves the value half way (arithmetic shift);
// otherwise the value becomes (old*weight + sample)/(weight+1). On the step path
// the result is registered from the CALC state; the averaging path waits in the
// DIV state for the shared restoring divider, which produces one quotient bit
// per cycle. A finished result waits in the DONE state until the output register
// is free, and the sequencer then returns to IDLE to accept the next sample.
// One transaction is in work at a time; a finished result waits in
// the output register while the next sample is accepted. All 16 smoothed
// values clear to zero at reset. Write configuration only while idle.
module adaptive_channel_smoothing_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration
  input  logic                              cfg_we_i,
  input  logic [acsf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [acsf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [acsf_pkg::CH_W-1:0]         channel_i,
  input  logic [acsf_pkg::DATA_W-1:0]       sample_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [acsf_pkg::CH_W-1:0]         channel_out_o,
  output logic [acsf_pkg::DATA_W-1:0]       smoothed_o
);
  import acsf_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [WEIGHT_W-1:0] weight_q;
  logic [DATA_W-1:0]   thresh_q;
  logic [DATA_W-1:0]   store_q [CHANNELS];

  logic [CH_W-1:0]     ch_q;
  logic [DATA_W-1:0]   smp_q;
  logic [DATA_W-1:0]   old_q;
  logic [DATA_W-1:0]   res_q, res_d;

  logic                out_valid_q, out_valid_d;
  logic [CH_W-1:0]     out_ch_q;
  logic [DATA_W-1:0]   out_val_q;

  logic                accept;
  logic                emit;
  logic [DATA_W:0]     diff;
  logic [DATA_W:0]     mag;
  logic [DATA_W:0]     half;
  logic [DATA_W:0]     step_sum;
  logic                rough;
  logic [NUM_W-1:0]    prod;
  logic [NUM_W-1:0]    num;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign accept = (state_q == S_IDLE) && in_valid_i;
  assign emit   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Difference, magnitude and half step
  assign diff     = {1'b0, smp_q} - {1'b0, old_q};
  assign mag      = diff[DATA_W] ? (~diff + 1'b1) : diff;
  assign rough    = mag >= {1'b0, thresh_q};
  assign half     = $unsigned($signed(diff) >>> 1);
  assign step_sum = {1'b0, old_q} + half;

  // Weighted sum for the averaging path, kept at full width
  assign prod = {{WEIGHT_W{1'b0}}, old_q} * {{DATA_W{1'b0}}, weight_q};
  assign num  = prod + {{WEIGHT_W{1'b0}}, smp_q};

  assign div_req.start = (state_q == S_CALC) && !rough;
  assign div_req.num   = num;
  assign div_req.den   = {1'b0, weight_q} + 1'b1;

  acsf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CALC;
      end
      S_CALC: begin
        if (rough) begin
          res_d   = step_sum[DATA_W-1:0];
          state_d = S_DONE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_d   = div_rsp.quot;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (emit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the output until taken, load a new result on emit
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) out_valid_d = 1'b1;
  end

  // Control state, configuration and smoothed values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      weight_q    <= WEIGHT_RST;
      thresh_q    <= THRESHOLD_RST;
      for (int k = 0; k < CHANNELS; k++) store_q[k] <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_WEIGHT:    weight_q <= cfg_data_i[WEIGHT_W-1:0];
          REG_THRESHOLD: thresh_q <= cfg_data_i[DATA_W-1:0];
          default: ;
        endcase
      end
      if (emit) store_q[ch_q] <= res_q;
    end
  end

  // Transaction payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q  <= channel_i;
      smp_q <= sample_i;
      old_q <= store_q[channel_i];
    end
    res_q <= res_d;
    if (emit) begin
      out_ch_q  <= ch_q;
      out_val_q <= res_q;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign channel_out_o = out_ch_q;
  assign smoothed_o    = out_val_q;

endmodule

// ===== hdl/acsf_div.sv =====
// Iterative radix-2 restoring divider, one quotient bit per cycle.
// Depends on acsf_pkg. The quotient must fit in DATA_W bits (numerator < divisor << DATA_W).
module acsf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acsf_pkg::div_req_t req_i,
  output acsf_pkg::div_rsp_t rsp_o
);
  import acsf_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0]  den_q, den_d;

  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    trial;

  // Trial subtract of the shifted remainder
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign trial   = shifted - {1'b0, den_q};

  // Load on start, then shift one bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DATA_W - 1);
      rem_d  = {1'b0, req_i.num[NUM_W-1:DATA_W]};
      quo_d  = req_i.num[DATA_W-1:0];
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (!trial[DEN_W]) begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DEN_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// ===== tb/sv/smoothed_value_checker.sv =====
// Checker for the adaptive channel smoothing filter: predicts each smoothed value
// and compares every output transaction against it, in order.
// Depends on acsf_pkg.
module smoothed_value_checker
  import acsf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port, observed
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input channel, observed
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [CH_W-1:0]       channel_i,
  input  logic [DATA_W-1:0]     sample_i,
  // Output channel, observed
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [CH_W-1:0]       channel_out_i,
  input  logic [DATA_W-1:0]     smoothed_i,
  // Status for the testbench top
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [DATA_W-1:0] value;
  } smoothed_result_t;

  smoothed_result_t    pending_smoothed[$];
  logic [WEIGHT_W-1:0] weight_q;
  logic [DATA_W-1:0]   threshold_q;
  logic [DATA_W-1:0]   channel_value[CHANNELS];
  int                  fail_count;
  int                  checked;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_smoothed.size();
  assign checked_o    = checked;

  // Next smoothed value: half step on a large difference, weighted average otherwise
  function automatic logic [DATA_W-1:0] next_smoothed(input logic [DATA_W-1:0]   old,
                                                      input logic [DATA_W-1:0]   smp,
                                                      input logic [WEIGHT_W-1:0] wgt,
                                                      input logic [DATA_W-1:0]   thr);
    logic signed [DATA_W+1:0] diff;
    logic signed [DATA_W+1:0] neg_diff;
    logic signed [DATA_W+1:0] moved;
    logic [DATA_W:0]          mag;
    logic [NUM_W:0]           old_w;
    logic [NUM_W:0]           smp_w;
    logic [NUM_W:0]           wgt_w;
    logic [NUM_W:0]           den_w;
    logic [NUM_W:0]           quot;
    diff     = $signed({2'b00, smp}) - $signed({2'b00, old});
    neg_diff = -diff;
    mag      = diff[DATA_W+1] ? neg_diff[DATA_W:0] : diff[DATA_W:0];
    if (mag >= {1'b0, thr}) begin
      // Arithmetic shift rounds toward minus infinity
      moved = $signed({2'b00, old}) + (diff >>> 1);
      return moved[DATA_W-1:0];
    end
    old_w = old;
    smp_w = smp;
    wgt_w = wgt;
    den_w = wgt_w + 1'b1;
    quot  = (old_w * wgt_w + smp_w) / den_w;
    return quot[DATA_W-1:0];
  endfunction

  // Print one line per mismatch, cap the output, always count
  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < 100) begin
      $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  // Track configuration, predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin : watch
    smoothed_result_t got;
    smoothed_result_t want;
    logic [DATA_W-1:0] value;
    if (!rst_ni) begin
      weight_q    <= WEIGHT_RST;
      threshold_q <= THRESHOLD_RST;
      for (int k = 0; k < CHANNELS; k++) begin
        channel_value[k] = '0;
      end
      pending_smoothed.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      // Compare first so a result never meets an expectation pushed at the same edge
      if (out_valid_i && !out_stall_i) begin
        got = '{channel: channel_out_i, value: smoothed_i};
        if (pending_smoothed.size() == 0) begin
          report_mismatch("unexpected result, channel/value", got.channel, got.value);
        end else begin
          want = pending_smoothed.pop_front();
          checked++;
          if (got.channel !== want.channel) begin
            report_mismatch("channel_out", got.channel, want.channel);
          end
          if (got.value !== want.value) begin
            report_mismatch("smoothed", got.value, want.value);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        value = '0;
        if (channel_i < CHANNELS) begin
          value = next_smoothed(channel_value[channel_i], sample_i, weight_q, threshold_q);
          channel_value[channel_i] = value;
        end
        pending_smoothed.push_back('{channel: channel_i, value: value});
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WEIGHT:    weight_q    <= cfg_data_i[WEIGHT_W-1:0];
          REG_THRESHOLD: threshold_q <= cfg_data_i[DATA_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top for the adaptive channel smoothing filter: clock, reset, stimulus,
// receiver stalls, watchdog and verdict.
// Depends on acsf_pkg, adaptive_channel_smoothing_filter and smoothed_value_checker.
module testbench;
  import acsf_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RANDOM_PHASES   = 10;
  localparam int PHASE_ITEMS     = 73;
  localparam int DRAIN_CYCLES    = 40;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [CH_W-1:0]       channel_i;
  logic [DATA_W-1:0]     sample_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [CH_W-1:0]       channel_out_o;
  logic [DATA_W-1:0]     smoothed_o;

  int                    fail_count;
  int                    pending;
  int                    checked;
  int                    samples_sent;
  int                    settings_applied;
  int                    hold_offs_done;
  int                    idle_cycles = 0;
  bit                    hold_off_req;
  bit                    rx_steady;
  bit                    tx_steady;
  logic [DATA_W-1:0]     last_sample[CHANNELS];

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  adaptive_channel_smoothing_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .channel_i     (channel_i),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .channel_out_o (channel_out_o),
    .smoothed_o    (smoothed_o)
  );

  smoothed_value_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .channel_i     (channel_i),
    .sample_i      (sample_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .channel_out_i (channel_out_o),
    .smoothed_i    (smoothed_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // Sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Sample: extremes, fully random, or close to the channel's recent input
  function automatic logic [DATA_W-1:0] pick_sample(input logic [CH_W-1:0] ch);
    int r;
    int span;
    int v;
    r = $urandom_range(0, 99);
    if (r < 10) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    if (r < 45) return DATA_W'($urandom_range(0, 65535));
    span = ($urandom_range(0, 3) == 0) ? 300 : 15;
    v = int'(last_sample[ch]) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return DATA_W'(v);
  endfunction

  // Offer one transaction and hold it until accepted, then idle for the gap
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [DATA_W-1:0] smp,
                             input int gap);
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    samples_sent++;
    last_sample[ch] = smp;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Write both registers; junk in the unused upper bits of the weight write
  task automatic apply_settings(input logic [WEIGHT_W-1:0] weight,
                                input logic [DATA_W-1:0] threshold);
    logic [CFG_DATA_W-1:0] wdata;
    wdata = CFG_DATA_W'($urandom);
    wdata[WEIGHT_W-1:0] = weight;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_WEIGHT;
    cfg_data_i  <= wdata;
    @(posedge clk_i);
    cfg_index_i <= REG_THRESHOLD;
    cfg_data_i  <= threshold;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  // Receiver: random stall pattern, long hold-off on request, steady when asked
  initial begin : receiver
    int r;
    int len;
    bit stall_now;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_off_req = 1'b0;
        hold_offs_done++;
      end else if (rx_steady) begin
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          stall_now = 1'b0;
          len = $urandom_range(1, 8);
        end else if (r < 95) begin
          stall_now = 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          stall_now = 1'b1;
          len = $urandom_range(20, 80);
        end
        out_stall_i <= stall_now;
        repeat (len - 1) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", pending);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int r;
    logic [WEIGHT_W-1:0] weight;
    logic [DATA_W-1:0]   threshold;
    logic [CH_W-1:0]     ch;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_WEIGHT;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    channel_i   = '0;
    sample_i    = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      last_sample[k] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: rough step up and down, fine path, threshold boundary
    send_sample(4'd0, 16'hFFFF, pick_gap());
    send_sample(4'd0, 16'h8000, pick_gap());
    send_sample(4'd0, 16'h0000, pick_gap());
    send_sample(4'd15, 16'd99, pick_gap());
    send_sample(4'd14, 16'd100, pick_gap());
    send_sample(4'd15, 16'd0, pick_gap());
    wait_drained();

    // Weight zero gives the sample itself; full-scale difference at top threshold
    apply_settings(8'd0, 16'hFFFF);
    send_sample(4'd1, 16'd12345, pick_gap());
    send_sample(4'd1, 16'hFFFF, pick_gap());
    send_sample(4'd2, 16'hFFFF, pick_gap());
    send_sample(4'd1, 16'h0000, pick_gap());
    wait_drained();

    // Threshold zero always takes the half step, even with no difference
    apply_settings(8'd255, 16'd0);
    send_sample(4'd3, 16'd1, pick_gap());
    send_sample(4'd3, 16'hFFFF, pick_gap());
    send_sample(4'd3, 16'h7FFF, pick_gap());
    wait_drained();

    // Largest weight on the fine path; full-scale steps still take the half step
    apply_settings(8'd255, 16'hFFFF);
    send_sample(4'd4, 16'd200, pick_gap());
    send_sample(4'd4, 16'hFFFF, pick_gap());
    send_sample(4'd4, 16'h0000, pick_gap());
    send_sample(4'd5, 16'hFFFF, pick_gap());
    wait_drained();

    // Smallest nonzero threshold
    apply_settings(8'd1, 16'd1);
    send_sample(4'd6, 16'd1, pick_gap());
    send_sample(4'd7, 16'd3, pick_gap());
    wait_drained();

    // Random phases, each with its own settings and idling mode
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      r = $urandom_range(0, 99);
      if (r < 15) weight = '0;
      else if (r < 30) weight = '1;
      else weight = WEIGHT_W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 10) threshold = '0;
      else if (r < 20) threshold = '1;
      else if (r < 35) threshold = DATA_W'($urandom_range(1, 8));
      else if (r < 80) threshold = DATA_W'($urandom_range(16, 4000));
      else threshold = DATA_W'($urandom_range(0, 65535));
      apply_settings(weight, threshold);

      tx_steady = (p == 2) || (p == 5);
      rx_steady = (p == 5);
      // Hold off the receiver while the sender keeps offering
      if (p == 2) hold_off_req = 1'b1;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        ch = CH_W'($urandom_range(0, CHANNELS - 1));
        send_sample(ch, pick_sample(ch), pick_gap());
      end
      wait_drained();
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Summary: %0d samples under %0d register settings, %0d results checked, %0d hold-offs",
             samples_sent, settings_applied, checked, hold_offs_done);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/acsf_pkg.sv
hdl/acsf_div.sv
hdl/adaptive_channel_smoothing_filter.sv
tb/sv/smoothed_value_checker.sv
tb/sv/testbench.sv
